// ===== hdl/biq_pkg.sv =====
`default_nettype none

package biq_pkg;

	// Default widths of the section
	localparam int DEF_SAMPLE_WIDTH   = 16;
	localparam int DEF_COEF_WIDTH     = 24;
	localparam int DEF_COEF_FRAC_BITS = 20;
	localparam int DEF_STATE_WIDTH    = 48;

	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int COEF_COUNT  = 5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NUM_ERR    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLIPPED    = 2'd3;

	// Input opcode
	localparam logic OP_CLEAR = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_B0      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_B1      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_B2      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_A1      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_A2      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COEFS_LOADED = 3'd5;

	// Control word fields
	typedef enum logic [1:0] {CND_NONE, CND_NOT_LOADED, CND_CLEAR, CND_Y_ERR} cond_t;
	typedef enum logic [2:0] {MA_B0, MA_B1, MA_B2, MA_A1, MA_A2} mul_a_t;
	typedef enum logic [1:0] {MB_X, MB_YLO, MB_YHI} mul_b_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_PROD, ACC_ADD_HI, ACC_FB_SUB} acc_op_t;
	typedef enum logic [1:0] {CAP_NONE, CAP_Y, CAP_N1} cap_op_t;
	typedef enum logic [2:0] {RET_NONE, RET_FILTER, RET_NOTLOAD, RET_CLEAR, RET_ERR} ret_t;

	localparam int UC_DEPTH = 13;
	typedef logic [3:0] step_t;

	// Program addresses
	localparam step_t UC_START = 4'd0;
	localparam step_t UC_YCAP  = 4'd1;
	localparam step_t UC_A1LO  = 4'd2;
	localparam step_t UC_A1HI  = 4'd3;
	localparam step_t UC_B1    = 4'd4;
	localparam step_t UC_A2LO  = 4'd5;
	localparam step_t UC_A2HI  = 4'd6;
	localparam step_t UC_B2    = 4'd7;
	localparam step_t UC_N2    = 4'd8;
	localparam step_t UC_DONE  = 4'd9;
	localparam step_t UC_NOTLD = 4'd10;
	localparam step_t UC_CLR   = 4'd11;
	localparam step_t UC_ERR   = 4'd12;

	typedef struct packed {
		cond_t   cond;
		step_t   target;
		mul_a_t  ma;
		mul_b_t  mb;
		acc_op_t acc;
		cap_op_t cap;
		ret_t    ret;
	} uc_word_t;

	localparam uc_word_t UC_NOP = '{cond: CND_NONE, target: UC_START, ma: MA_B0, mb: MB_X,
		acc: ACC_HOLD, cap: CAP_NONE, ret: RET_NONE};

	// Sequencer to datapath
	typedef struct packed {
		logic     start;
		logic     fire;
		uc_word_t word;
	} dp_ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic y_err;
		logic clear_op;
	} dp_flags_t;

	// Microprogram: the multiply issued in a step lands in the product
	// register, and the accumulate of the next step consumes it.
	function automatic uc_word_t uc_rom(step_t step);
		uc_word_t w;
		w = UC_NOP;
		case (step)
			UC_START: begin
				w.ma = MA_B0; w.mb = MB_X;
				w.cond = CND_NOT_LOADED; w.target = UC_NOTLD;
			end
			UC_YCAP: begin
				w.cap = CAP_Y;
				w.cond = CND_CLEAR; w.target = UC_CLR;
			end
			UC_A1LO: begin
				w.ma = MA_A1; w.mb = MB_YLO;
				w.cond = CND_Y_ERR; w.target = UC_ERR;
			end
			UC_A1HI: begin
				w.ma = MA_A1; w.mb = MB_YHI; w.acc = ACC_PROD;
			end
			UC_B1: begin
				w.ma = MA_B1; w.mb = MB_X; w.acc = ACC_ADD_HI;
			end
			UC_A2LO: begin
				w.ma = MA_A2; w.mb = MB_YLO; w.acc = ACC_FB_SUB;
			end
			UC_A2HI: begin
				w.ma = MA_A2; w.mb = MB_YHI; w.acc = ACC_PROD; w.cap = CAP_N1;
			end
			UC_B2: begin
				w.ma = MA_B2; w.mb = MB_X; w.acc = ACC_ADD_HI;
			end
			UC_N2:    w.acc = ACC_FB_SUB;
			UC_DONE:  w.ret = RET_FILTER;
			UC_NOTLD: w.ret = RET_NOTLOAD;
			UC_CLR:   w.ret = RET_CLEAR;
			UC_ERR:   w.ret = RET_ERR;
			default:  w = UC_NOP;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/biq_if.sv =====
`default_nettype none

interface biq_sample_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, opcode, sample_in, input ready);
	modport sink (input valid, opcode, sample_in, output ready);
endinterface

interface biq_result_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic [1:0]                     status;

	modport source (output valid, sample_out, status, input ready);
	modport sink (input valid, sample_out, status, output ready);
endinterface

interface biq_cfg_if #(parameter int INDEX_W = 3, parameter int DATA_W = 24);
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] index;
	logic [DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/biq_datapath.sv =====
`default_nettype none

module biq_datapath
	import biq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH     = DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
	parameter int STATE_WIDTH    = DEF_STATE_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dp_ctrl_t                       ctrl,
	input  wire logic                           cfg_clear,
	input  wire logic signed [COEF_WIDTH-1:0]   coef [COEF_COUNT],
	input  wire logic                           opcode,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output dp_flags_t                           flags,
	output logic signed [SAMPLE_WIDTH-1:0]      res_sample,
	output logic [STATUS_W-1:0]                 res_status
);

	// The state word is multiplied in two halves: low half unsigned, high half signed
	localparam int LO_W    = STATE_WIDTH / 2;
	localparam int HI_W    = STATE_WIDTH - LO_W;
	localparam int OPB_A   = (HI_W > LO_W + 1) ? HI_W : LO_W + 1;
	localparam int OPB_W   = (SAMPLE_WIDTH > OPB_A) ? SAMPLE_WIDTH : OPB_A;
	localparam int PROD_W  = COEF_WIDTH + OPB_W;
	localparam int WIDE_W  = (STATE_WIDTH > OPB_W) ? STATE_WIDTH : OPB_W;
	localparam int ACC_W   = COEF_WIDTH + WIDE_W + 2;
	localparam int RND_W   = STATE_WIDTH + SAMPLE_WIDTH;
	localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                           op_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [STATE_WIDTH-1:0]  y_q;
	logic signed [STATE_WIDTH-1:0]  n1_q;
	logic                           y_err_q;
	logic                           n1_err_q;
	logic signed [STATE_WIDTH-1:0]  d1_q;
	logic signed [STATE_WIDTH-1:0]  d2_q;

	logic signed [COEF_WIDTH-1:0] opa;
	logic signed [OPB_W-1:0]      opb;
	logic signed [ACC_W-1:0]      prod_ext;
	logic signed [ACC_W-1:0]      ysum;
	logic signed [ACC_W-1:0]      n1sum;
	logic                         y_fits;
	logic                         n1_fits;
	logic                         n2_fits;
	logic                         filt_ok;
	logic signed [RND_W-1:0]      rnd_sum;
	logic signed [RND_W-1:0]      rnd;
	logic                         rnd_fits;

	// Select multiplier operands
	always_comb begin
		opa = coef[ctrl.word.ma];
		case (ctrl.word.mb)
			MB_X:    opb = OPB_W'(x_q);
			MB_YLO:  opb = OPB_W'({1'b0, y_q[LO_W-1:0]});
			MB_YHI:  opb = OPB_W'($signed(y_q[STATE_WIDTH-1:LO_W]));
			default: opb = OPB_W'(x_q);
		endcase
	end

	// Sums and range checks
	always_comb begin
		prod_ext = ACC_W'(prod_q);
		ysum     = prod_ext + ACC_W'(d1_q);
		n1sum    = acc_q + ACC_W'(d2_q);
		y_fits   = (&ysum[ACC_W-1:STATE_WIDTH-1]) | ~(|ysum[ACC_W-1:STATE_WIDTH-1]);
		n1_fits  = (&n1sum[ACC_W-1:STATE_WIDTH-1]) | ~(|n1sum[ACC_W-1:STATE_WIDTH-1]);
		n2_fits  = (&acc_q[ACC_W-1:STATE_WIDTH-1]) | ~(|acc_q[ACC_W-1:STATE_WIDTH-1]);
		filt_ok  = !n1_err_q && n2_fits;
		rnd_sum  = RND_W'(y_q) + RND_HALF;
		rnd      = rnd_sum >>> COEF_FRAC_BITS;
		rnd_fits = (&rnd[RND_W-1:SAMPLE_WIDTH-1]) | ~(|rnd[RND_W-1:SAMPLE_WIDTH-1]);
	end

	// Multiply, accumulate and capture
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q  <= sample_in;
			op_q <= opcode;
		end
		prod_q <= opa * opb;
		case (ctrl.word.acc)
			ACC_PROD:   acc_q <= prod_ext;
			ACC_ADD_HI: acc_q <= acc_q + (prod_ext <<< LO_W);
			ACC_FB_SUB: acc_q <= prod_ext - (acc_q >>> COEF_FRAC_BITS);
			default:    acc_q <= acc_q;
		endcase
		case (ctrl.word.cap)
			CAP_Y: begin
				y_q     <= ysum[STATE_WIDTH-1:0];
				y_err_q <= !y_fits;
			end
			CAP_N1: begin
				n1_q     <= n1sum[STATE_WIDTH-1:0];
				n1_err_q <= !n1_fits;
			end
			default: ;
		endcase
	end

	// Delay states: reset, config clear, op clear, or commit of a good filter step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (cfg_clear) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (ctrl.fire) begin
			if (ctrl.word.ret == RET_CLEAR) begin
				d1_q <= '0;
				d2_q <= '0;
			end else if (ctrl.word.ret == RET_FILTER && filt_ok) begin
				d1_q <= n1_q;
				d2_q <= acc_q[STATE_WIDTH-1:0];
			end
		end
	end

	// Result of the retiring step
	always_comb begin
		res_sample = '0;
		res_status = ST_OK;
		case (ctrl.word.ret)
			RET_FILTER: begin
				if (!filt_ok) begin
					res_status = ST_NUM_ERR;
				end else if (rnd_fits) begin
					res_sample = rnd[SAMPLE_WIDTH-1:0];
				end else begin
					res_sample = rnd[RND_W-1] ? SAT_MIN : SAT_MAX;
					res_status = ST_CLIPPED;
				end
			end
			RET_NOTLOAD: res_status = ST_NOT_LOADED;
			RET_ERR:     res_status = ST_NUM_ERR;
			default:     res_status = ST_OK;
		endcase
	end

	assign flags.y_err    = y_err_q;
	assign flags.clear_op = (op_q == OP_CLEAR);

endmodule

`default_nettype wire

// ===== hdl/biq_sequencer.sv =====
`default_nettype none

module biq_sequencer
	import biq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      loaded,
	input  wire logic      out_free,
	input  wire dp_flags_t flags,
	output dp_ctrl_t       ctrl
);

	logic     busy_q;
	step_t    step_q;
	logic     busy_d;
	step_t    step_d;
	uc_word_t word;
	logic     take_jump;
	logic     is_ret;

	// Fetch, branch and advance
	always_comb begin
		word = uc_rom(step_q);
		case (word.cond)
			CND_NOT_LOADED: take_jump = !loaded;
			CND_CLEAR:      take_jump = flags.clear_op;
			CND_Y_ERR:      take_jump = flags.y_err;
			default:        take_jump = 1'b0;
		endcase
		is_ret     = (word.ret != RET_NONE);
		in_ready   = !busy_q;
		ctrl.start = !busy_q && in_valid;
		ctrl.fire  = busy_q && is_ret && out_free;
		ctrl.word  = busy_q ? word : UC_NOP;

		busy_d = busy_q;
		step_d = step_q;
		if (!busy_q) begin
			if (in_valid) begin
				busy_d = 1'b1;
				step_d = UC_START;
			end
		end else if (is_ret) begin
			// hold the retire step until the output register frees up
			if (out_free) begin
				busy_d = 1'b0;
			end
		end else begin
			step_d = take_jump ? word.target : step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= UC_START;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

	a_step_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < UC_DEPTH))
		else $error("step counter left the program");

	a_start_enters_program: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> (busy_q && step_q == UC_START))
		else $error("accepted beat did not start the program");

	a_fire_ends_program: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire |=> !busy_q)
		else $error("sequencer stayed busy after retiring");

endmodule

`default_nettype wire

// ===== hdl/biquad_iir_filter_core.sv =====
`default_nettype none
// Biquad IIR section, transposed direct form II, fixed point.
// sample_ch carries one beat per item: opcode (filter or clear) and a signed
// sample. result_ch returns exactly one beat per item: the filtered sample and
// a status (ok, not loaded, numerical error with state kept, clipped).
// cfg writes the five coefficients and the loaded flag by register index;
// writing the loaded flag also zeroes both delay states. cfg is always ready
// and must only be written while the block is idle.
// One shared signed multiplier (coefficient by sample or by half of the state
// word) runs a 13-word microprogram. A filter beat occupies the sequencer from
// acceptance to its retire step, and no new sample is taken while it is busy;
// the result is loaded into the output register when that step retires. A beat
// that finds the block not loaded, a clear or an error on y jumps to its retire step.
// The output register frees the sequencer while a result waits: if the
// receiver stalls, the next item is accepted and runs up to its retire step,
// where it holds until the pending result is taken.
// Reset clears coefficients, the loaded flag, both delays, the sequencer and the output valid flag.
module biquad_iir_filter_core
	import biq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH     = DEF_COEF_WIDTH,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
	parameter int STATE_WIDTH    = DEF_STATE_WIDTH
) (
	input wire logic     clk,
	input wire logic     arst_n,
	biq_sample_if.sink   sample_ch,
	biq_result_if.source result_ch,
	biq_cfg_if.sink      cfg
);

	logic signed [COEF_WIDTH-1:0]   coef_q [COEF_COUNT];
	logic                           loaded_q;
	logic                           cfg_clear;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic [STATUS_W-1:0]            out_status_q;
	logic                           out_free;
	logic                           in_ready;
	dp_ctrl_t                       ctrl;
	dp_flags_t                      flags;
	logic signed [SAMPLE_WIDTH-1:0] res_sample;
	logic [STATUS_W-1:0]            res_status;

	// Configuration registers
	assign cfg.ready = 1'b1;
	assign cfg_clear = cfg.valid && (cfg.index == REG_COEFS_LOADED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_COUNT; i++) begin
				coef_q[i] <= '0;
			end
			loaded_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COEF_B0:      coef_q[MA_B0] <= cfg.data;
				REG_COEF_B1:      coef_q[MA_B1] <= cfg.data;
				REG_COEF_B2:      coef_q[MA_B2] <= cfg.data;
				REG_COEF_A1:      coef_q[MA_A1] <= cfg.data;
				REG_COEF_A2:      coef_q[MA_A2] <= cfg.data;
				REG_COEFS_LOADED: loaded_q <= cfg.data[0];
				default:          ;
			endcase
		end
	end

	biq_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (in_ready),
		.loaded   (loaded_q),
		.out_free (out_free),
		.flags    (flags),
		.ctrl     (ctrl)
	);

	biq_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_WIDTH     (COEF_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.STATE_WIDTH    (STATE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg_clear  (cfg_clear),
		.coef       (coef_q),
		.opcode     (sample_ch.opcode),
		.sample_in  (sample_ch.sample_in),
		.flags      (flags),
		.res_sample (res_sample),
		.res_status (res_status)
	);

	assign sample_ch.ready = in_ready;

	// Output register: load on retire, drop when the beat is taken
	assign out_free = !out_valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			out_sample_q <= res_sample;
			out_status_q <= res_status;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_sample_q;
	assign result_ch.status     = out_status_q;

endmodule

`default_nettype wire

// ===== tb/biquad_filter_checker.sv =====
`default_nettype none

module biquad_filter_checker
	import biq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	biq_sample_if    sample_ch,
	biq_result_if    result_ch,
	biq_cfg_if       cfg,
	output int       fail_count,
	output int       pending,
	output int       status_seen [4]
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW  = DEF_SAMPLE_WIDTH;
	localparam int CW  = DEF_COEF_WIDTH;
	localparam int FB  = DEF_COEF_FRAC_BITS;
	localparam int STW = DEF_STATE_WIDTH;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [SW-1:0]   sample_out;
		logic [STATUS_W-1:0]    status;
	} filt_result_t;

	// Shadow of the section: coefficients by register index, loaded flag, delays
	logic signed [CW-1:0]  coef [COEF_COUNT];
	logic                  loaded;
	logic signed [STW-1:0] delay_one;
	logic signed [STW-1:0] delay_two;

	filt_result_t expected_q [$];

	function automatic logic fits_width(wide_t v, int w);
		wide_t lim;
		lim = 1;
		lim = lim << (w - 1);
		return (v >= -lim) && (v < lim);
	endfunction

	// Advance the shadow state by one input beat and return its result
	function automatic filt_result_t filter_step(logic op, logic signed [SW-1:0] x_in);
		filt_result_t res;
		wide_t x, y, n1, n2, r, half;
		wide_t b0, b1, b2, a1, a2, d1, d2;
		res.sample_out = '0;
		res.status     = ST_OK;
		if (!loaded) begin
			res.status = ST_NOT_LOADED;
			return res;
		end
		if (op == OP_CLEAR) begin
			delay_one = '0;
			delay_two = '0;
			return res;
		end
		x  = x_in;
		b0 = coef[REG_COEF_B0];
		b1 = coef[REG_COEF_B1];
		b2 = coef[REG_COEF_B2];
		a1 = coef[REG_COEF_A1];
		a2 = coef[REG_COEF_A2];
		d1 = delay_one;
		d2 = delay_two;
		y = b0 * x + d1;
		if (!fits_width(y, STW)) begin
			res.status = ST_NUM_ERR;
			return res;
		end
		// Feedback products are floored back into the state format
		n1 = b1 * x - ((a1 * y) >>> FB) + d2;
		n2 = b2 * x - ((a2 * y) >>> FB);
		if (!fits_width(n1, STW) || !fits_width(n2, STW)) begin
			res.status = ST_NUM_ERR;
			return res;
		end
		delay_one = n1[STW-1:0];
		delay_two = n2[STW-1:0];
		// Round half up, then saturate into the sample width
		half = 1;
		half = half << (FB - 1);
		r = (y + half) >>> FB;
		if (fits_width(r, SW)) begin
			res.sample_out = r[SW-1:0];
		end else begin
			res.sample_out = (r < 0) ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			res.status     = ST_CLIPPED;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		filt_result_t want;
		if (!arst_n) begin
			foreach (coef[i]) coef[i] = '0;
			loaded     = 1'b0;
			delay_one  = '0;
			delay_two  = '0;
			expected_q.delete();
			fail_count = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		end else begin
			// Compare a result beat against the oldest expectation
			if (result_ch.valid && result_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected: sample_out %0d status %0d",
						result_ch.sample_out, result_ch.status);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					status_seen[want.status]++;
					if (result_ch.sample_out !== want.sample_out) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							want.sample_out, result_ch.sample_out);
						fail_count++;
					end
					if (result_ch.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, result_ch.status);
						fail_count++;
					end
				end
			end
			// Track register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_A1, REG_COEF_A2: begin
						coef[cfg.index] = cfg.data;
					end
					REG_COEFS_LOADED: begin
						loaded    = cfg.data[0];
						delay_one = '0;
						delay_two = '0;
					end
					default: ;
				endcase
			end
			// Predict the result of each accepted input beat
			if (sample_ch.valid && sample_ch.ready)
				expected_q.push_back(filter_step(sample_ch.opcode, sample_ch.sample_in));
		end
		pending = expected_q.size();
	end

endmodule

`default_nettype wire

// ===== tb/tb_biquad_iir_filter_core.sv =====
`default_nettype none

module tb_biquad_iir_filter_core;
	timeunit 1ns;
	timeprecision 1ps;
	import biq_pkg::*;

	localparam int SW          = DEF_SAMPLE_WIDTH;
	localparam int CW          = DEF_COEF_WIDTH;
	localparam int COEF_ONE    = 1 << DEF_COEF_FRAC_BITS;
	localparam int COEF_MAX    = (1 << (CW - 1)) - 1;
	localparam int COEF_MIN    = -(1 << (CW - 1));
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic OP_FILTER = ~OP_CLEAR;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	// Indexes past the last register; writes there must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [CFG_INDEX_W-1:0] COEF_REG [COEF_COUNT] = '{
		REG_COEF_B0, REG_COEF_B1, REG_COEF_B2, REG_COEF_A1, REG_COEF_A2};

	typedef enum int {TRAF_STEADY, TRAF_SEND_IDLE, TRAF_RECV_STALL, TRAF_BOTH} traffic_t;
	typedef enum int {CSET_STABLE, CSET_RANDOM, CSET_EXTREME, CSET_HOT} coef_kind_t;

	logic clk;
	logic arst_n;

	biq_sample_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
	biq_result_if #(.SAMPLE_WIDTH(SW)) result_ch ();
	biq_cfg_if #(.INDEX_W(CFG_INDEX_W), .DATA_W(CW)) cfg ();

	int check_fails;
	int check_pending;
	int status_seen [4];

	int send_idle_pct;
	int stall_pct;
	int hold_requests;
	int hold_served;
	int hold_left;
	int cycle_count;
	int beats_sent;
	int coef_set [COEF_COUNT];

	biquad_iir_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg       (cfg)
	);

	biquad_filter_checker filt_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_ch   (sample_ch),
		.result_ch   (result_ch),
		.cfg         (cfg),
		.fail_count  (check_fails),
		.pending     (check_pending),
		.status_seen (status_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Abort a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drive result ready: random stalls plus the occasional long hold-off
	initial begin
		hold_served = 0;
		hold_left   = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result_ch.ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
			end
		end
	end

	task automatic set_traffic(traffic_t mode);
		case (mode)
			TRAF_STEADY:     begin send_idle_pct = 0;  stall_pct = 0;  end
			TRAF_SEND_IDLE:  begin send_idle_pct = 78; stall_pct = 0;  end
			TRAF_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 78; end
			default:         begin send_idle_pct = 26; stall_pct = 26; end
		endcase
	endtask

	// Offer one beat after a random gap; valid stays high for a following beat
	task automatic send_beat(logic op, logic signed [SW-1:0] x);
		int gap;
		gap = 0;
		while (int'($urandom_range(99)) < send_idle_pct) gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.opcode    <= op;
		sample_ch.sample_in <= x;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		beats_sent++;
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (check_pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	// Write the selected coefficients, optionally the spare indexes and the loaded flag
	task automatic apply_config(logic [COEF_COUNT-1:0] wr_mask, bit wr_loaded, bit load_val,
		bit poke_spare);
		logic [CW-1:0] d;
		for (int i = 0; i < COEF_COUNT; i++)
			if (wr_mask[i]) cfg_write(COEF_REG[i], CW'(coef_set[i]));
		if (poke_spare) begin
			cfg_write(REG_SPARE_LO, CW'($urandom()));
			cfg_write(REG_SPARE_HI, CW'($urandom()));
		end
		if (wr_loaded) begin
			d    = CW'($urandom());
			d[0] = load_val;
			cfg_write(REG_COEFS_LOADED, d);
		end
		cfg.valid <= 1'b0;
	endtask

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Pick a coefficient set of the given flavor into coef_set
	task automatic pick_coefs(coef_kind_t kind);
		int a2;
		int lim;
		case (kind)
			CSET_RANDOM: begin
				foreach (coef_set[i]) coef_set[i] = int'($urandom());
			end
			CSET_EXTREME: begin
				foreach (coef_set[i]) begin
					case ($urandom_range(4))
						0: coef_set[i] = COEF_MIN;
						1: coef_set[i] = COEF_MAX;
						2: coef_set[i] = 0;
						3: coef_set[i] = COEF_ONE;
						default: coef_set[i] = -COEF_ONE;
					endcase
				end
			end
			default: begin
				// Keep the poles inside the unit circle
				a2  = rand_between(-(COEF_ONE * 9) / 10, (COEF_ONE * 9) / 10);
				lim = ((COEF_ONE + a2) / 100) * 95;
				coef_set[3] = rand_between(-lim, lim);
				coef_set[4] = a2;
				for (int i = 0; i < 3; i++)
					coef_set[i] = (kind == CSET_HOT) ? rand_between(COEF_MIN, COEF_MAX)
						: rand_between(-COEF_ONE, COEF_ONE);
			end
		endcase
	endtask

	task automatic random_beat();
		logic signed [SW-1:0] x;
		logic                 op;
		op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_FILTER;
		case ($urandom_range(9))
			0, 1: x = SW'(rand_between(-256, 256));
			2, 3: begin
				case ($urandom_range(4))
					0: x = SAMPLE_MAX;
					1: x = SAMPLE_MIN;
					2: x = '0;
					3: x = SW'(1);
					default: x = '1;
				endcase
			end
			default: x = SW'($urandom());
		endcase
		send_beat(op, x);
	endtask

	initial begin
		coef_kind_t kind;
		bit         wr_loaded;
		bit         load_val;

		hold_requests = 0;
		beats_sent    = 0;
		set_traffic(TRAF_STEADY);
		arst_n              <= 1'b0;
		sample_ch.valid     <= 1'b0;
		sample_ch.opcode    <= OP_FILTER;
		sample_ch.sample_in <= '0;
		cfg.valid           <= 1'b0;
		cfg.index           <= REG_COEF_B0;
		cfg.data            <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Not loaded after reset: both opcodes answer with the not-loaded status
		send_beat(OP_FILTER, SAMPLE_MAX);
		send_beat(OP_CLEAR, SAMPLE_MIN);
		drain();

		// Half-unit b0 hits the rounding tie; extreme b1 and b2 drive clipping
		coef_set = '{COEF_ONE / 2, COEF_MIN, COEF_MAX, 0, 0};
		apply_config('1, 1'b1, 1'b1, 1'b0);
		send_beat(OP_FILTER, SW'(1));
		send_beat(OP_FILTER, '1);
		send_beat(OP_FILTER, '0);
		send_beat(OP_CLEAR, '0);
		send_beat(OP_FILTER, SAMPLE_MAX);
		send_beat(OP_FILTER, SAMPLE_MIN);
		send_beat(OP_FILTER, SAMPLE_MAX);
		drain();

		// Unstable section: state runs out of range, is kept, then cleared
		coef_set = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN};
		apply_config('1, 1'b1, 1'b1, 1'b1);
		repeat (7) send_beat(OP_FILTER, SAMPLE_MAX);
		send_beat(OP_CLEAR, SAMPLE_MAX);
		repeat (3) send_beat(OP_FILTER, SAMPLE_MIN);
		send_beat(OP_CLEAR, '0);
		drain();

		// Drop the loaded flag
		apply_config('0, 1'b1, 1'b0, 1'b0);
		send_beat(OP_FILTER, SW'(5));
		send_beat(OP_CLEAR, SW'(5));
		drain();

		// Random phases under each traffic pattern
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			set_traffic(traffic_t'(phase % 4));
			kind = (phase == 0) ? CSET_STABLE : coef_kind_t'($urandom_range(3));
			if ($urandom_range(9) < 5) kind = CSET_STABLE;
			pick_coefs(kind);
			wr_loaded = (phase == 0) || ($urandom_range(9) < 8);
			load_val  = (phase == 0) || ($urandom_range(9) < 9);
			apply_config((phase == 0) ? '1 : COEF_COUNT'($urandom()), wr_loaded, load_val,
				$urandom_range(3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 2 && k == 20) hold_requests++;
				random_beat();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d beats over %0d random coefficient phases plus directed cases",
			beats_sent, NUM_PHASES);
		$display("Results: %0d ok, %0d not loaded, %0d numerical error, %0d clipped",
			status_seen[ST_OK], status_seen[ST_NOT_LOADED], status_seen[ST_NUM_ERR],
			status_seen[ST_CLIPPED]);
		if (check_fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/biq_pkg.sv
hdl/biq_if.sv
hdl/biq_datapath.sv
hdl/biq_sequencer.sv
hdl/biquad_iir_filter_core.sv
tb/biquad_filter_checker.sv
tb/tb_biquad_iir_filter_core.sv
